>>> rtl/bcps_pkg.sv
// ----------------------------------------------------------------------------
// bcps_pkg
// Shared types and constants of the collision pair scheduler.
// ----------------------------------------------------------------------------
package bcps_pkg;

  localparam int CNT_W        = 5;   // width of a particle count
  localparam int IDX_W        = 4;   // width of an emitted particle index
  localparam int TAG_W        = 10;  // width of a cell coordinate
  localparam int RES_W        = 6;   // width of the per-cell result counter
  localparam int RESULT_CAP   = 34;  // pairs kept per cell; later ones drop
  localparam int MAX_PER_CELL = 16;  // cell capacity; larger counts saturate

  typedef enum logic [1:0] {
    KIND_II = 2'd0,
    KIND_EE = 2'd1,
    KIND_EI = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
  } pair_t;

  // Job handed from the top level to the pair sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] ni;    // saturated ion count
    logic [CNT_W-1:0] ne;    // saturated electron count
    logic [CNT_W-1:0] quot;  // larger count / smaller count
    logic [CNT_W-1:0] rem;   // larger count % smaller count
  } job_t;

endpackage

>>> rtl/bcps_div.sv
// ----------------------------------------------------------------------------
// bcps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcps_div
  import bcps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] quot_o,
  output logic [CNT_W-1:0] rem_o
);

  localparam int StepW = $clog2(CNT_W + 1);

  logic [StepW-1:0] step_q;
  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] quot_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dsor_q;

  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             fits;

  // Shift the next dividend bit in and try to subtract the divisor.
  assign shifted = {rem_q, quot_q[CNT_W-1]};
  assign diff    = shifted - {1'b0, dsor_q};
  assign fits    = (shifted >= {1'b0, dsor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(CNT_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsor_q <= divisor_i;
    end else if (run_q) begin
      quot_q <= {quot_q[CNT_W-2:0], fits};
      rem_q  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/bcps_gen.sv
// ----------------------------------------------------------------------------
// bcps_gen
// Pair sequencer: walks the pair phases of one cell, one pair per cycle within a phase.
// ----------------------------------------------------------------------------
module bcps_gen
  import bcps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  job_t  job_i,
  output logic  pair_valid_o,
  output pair_t pair_o,
  output logic  done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVEN_II,
    ST_EVEN_EE,
    ST_ODD_II,
    ST_ODD_EE,
    ST_EI
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [1:0]       t_q, t_d;
  logic [CNT_W-1:0] s_q, s_d;
  logic [CNT_W:0]   j_q, j_d;
  logic [RES_W-1:0] cnt_q, cnt_d;
  logic             valid_q, valid_d;
  logic             done_q, done_d;
  pair_t            pair_q, pair_d;

  logic [CNT_W-1:0] n;
  kind_e            kind;
  logic [CNT_W:0]   k_next;
  logic             even_ok;
  logic             odd_en;
  logic             big_is_ion;
  logic [CNT_W-1:0] big;
  logic [CNT_W-1:0] small_n;
  logic [CNT_W:0]   glen;
  logic             capped;

  always_comb begin
    if (state_q == ST_EVEN_II || state_q == ST_ODD_II) begin
      n    = job_i.ni;
      kind = KIND_II;
    end else begin
      n    = job_i.ne;
      kind = KIND_EE;
    end
  end

  assign k_next     = {1'b0, k_q} + 1'b1;
  assign even_ok    = !n[0] && (k_next < {1'b0, n});
  assign odd_en     = n[0] && (n >= CNT_W'(3));
  assign big_is_ion = (job_i.ni > job_i.ne);
  assign big        = big_is_ion ? job_i.ni : job_i.ne;
  assign small_n    = big_is_ion ? job_i.ne : job_i.ni;
  assign glen       = (s_q < job_i.rem) ? ({1'b0, job_i.quot} + 1'b1) : {1'b0, job_i.quot};
  assign capped     = (cnt_q == RES_W'(RESULT_CAP));

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    t_d     = t_q;
    s_d     = s_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    done_d  = 1'b0;
    pair_d  = pair_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EVEN_II;
          k_d     = '0;
          t_d     = '0;
          cnt_d   = '0;
        end
      end
      ST_EVEN_II, ST_EVEN_EE: begin
        if (capped) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else if (even_ok) begin
          valid_d = 1'b1;
          pair_d  = '{kind: kind, first: k_q[IDX_W-1:0], second: k_next[IDX_W-1:0]};
          k_d     = k_q + CNT_W'(2);
          cnt_d   = cnt_q + 1'b1;
        end else if (state_q == ST_EVEN_II) begin
          state_d = ST_EVEN_EE;
          k_d     = '0;
        end else begin
          state_d = ST_ODD_II;
          k_d     = CNT_W'(3);
          t_d     = '0;
        end
      end
      ST_ODD_II, ST_ODD_EE: begin
        if (capped) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else if (odd_en && t_q != 2'd3) begin
          // Triangle over the first three particles.
          valid_d = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          t_d     = t_q + 1'b1;
          case (t_q)
            2'd0:    pair_d = '{kind: kind, first: IDX_W'(0), second: IDX_W'(1)};
            2'd1:    pair_d = '{kind: kind, first: IDX_W'(1), second: IDX_W'(2)};
            default: pair_d = '{kind: kind, first: IDX_W'(2), second: IDX_W'(0)};
          endcase
        end else if (odd_en && (k_next < {1'b0, n})) begin
          valid_d = 1'b1;
          pair_d  = '{kind: kind, first: k_q[IDX_W-1:0], second: k_next[IDX_W-1:0]};
          k_d     = k_q + CNT_W'(2);
          cnt_d   = cnt_q + 1'b1;
        end else if (state_q == ST_ODD_II) begin
          state_d = ST_ODD_EE;
          k_d     = CNT_W'(3);
          t_d     = '0;
        end else begin
          state_d = ST_EI;
          k_d     = '0;
          s_d     = '0;
          j_d     = '0;
        end
      end
      ST_EI: begin
        if (capped) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else if (job_i.ni == job_i.ne) begin
          if (k_q < job_i.ne) begin
            valid_d = 1'b1;
            pair_d  = '{kind: KIND_EI, first: k_q[IDX_W-1:0], second: k_q[IDX_W-1:0]};
            k_d     = k_q + 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end else begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end else if (small_n != '0 && k_q < big) begin
          // Spread the larger species: group s takes glen partners.
          valid_d = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          k_d     = k_q + 1'b1;
          if (big_is_ion) begin
            pair_d = '{kind: KIND_EI, first: s_q[IDX_W-1:0], second: k_q[IDX_W-1:0]};
          end else begin
            pair_d = '{kind: KIND_EI, first: k_q[IDX_W-1:0], second: s_q[IDX_W-1:0]};
          end
          if ((j_q + 1'b1) == glen) begin
            s_d = s_q + 1'b1;
            j_d = '0;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      k_q     <= '0;
      t_q     <= '0;
      s_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      t_q     <= t_d;
      s_q     <= s_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign pair_valid_o = valid_q;
  assign pair_o       = pair_q;
  assign done_o       = done_q;

endmodule

>>> rtl/binary_collision_pair_scheduler.sv
// ----------------------------------------------------------------------------
// binary_collision_pair_scheduler
// Builds the binary collision pair list of one grid cell.
// ----------------------------------------------------------------------------
// Pulse start_i with the ion and electron counts and the cell coordinates
// while busy_o is low. The block then emits the cell's pairs, one per cycle
// apart from gaps at phase changes, each marked by result_valid_o for exactly
// one cycle; the receiver has no way to stall them, so it must take every
// strobe. Order: even-count ion-ion, even-count electron-electron, odd-count
// ion-ion, odd-count electron-electron, then electron-ion. last_pair_o marks
// the final pair of the cell; a cell with no pairs emits nothing. Counts above
// MAX_PER_CELL saturate, and at most 34 pairs are kept per cell. A cell passes
// through the bit-serial count divider and then the pair sequencer; a one-pair
// hold stage lets the last pair be flagged.
module binary_collision_pair_scheduler
  import bcps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [CNT_W-1:0] ion_count_i,
  input  logic [CNT_W-1:0] electron_count_i,
  input  logic [TAG_W-1:0] cell_r_i,
  input  logic [TAG_W-1:0] cell_z_i,
  output logic             result_valid_o,
  output logic [1:0]       pair_kind_o,
  output logic [IDX_W-1:0] first_index_o,
  output logic [IDX_W-1:0] second_index_o,
  output logic [TAG_W-1:0] tag_r_o,
  output logic [TAG_W-1:0] tag_z_o,
  output logic             last_pair_o
);

  localparam int CmpW = $clog2(MAX_PER_CELL + 1) + CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_GEN
  } state_e;

  state_e           state_q, state_d;
  logic             accept;
  logic [CNT_W-1:0] ni_sat;
  logic [CNT_W-1:0] ne_sat;
  logic [CNT_W-1:0] ni_q;
  logic [CNT_W-1:0] ne_q;
  logic [TAG_W-1:0] tag_r_q;
  logic [TAG_W-1:0] tag_z_q;

  logic             div_done;
  logic [CNT_W-1:0] div_quot;
  logic [CNT_W-1:0] div_rem;
  logic             gen_start;
  job_t             job;
  logic             gen_valid;
  pair_t            gen_pair;
  logic             gen_done;

  // One-pair hold stage: a pair leaves only once we know whether another follows.
  logic             hold_valid_q;
  pair_t            hold_q;

  logic             res_valid_q;
  pair_t            res_pair_q;
  logic             res_last_q;
  logic [TAG_W-1:0] res_r_q;
  logic [TAG_W-1:0] res_z_q;

  assign accept = start_i && (state_q == ST_IDLE);

  // Saturate each count to the cell capacity.
  assign ni_sat = (CmpW'(ion_count_i) > CmpW'(MAX_PER_CELL)) ?
                  CNT_W'(MAX_PER_CELL) : ion_count_i;
  assign ne_sat = (CmpW'(electron_count_i) > CmpW'(MAX_PER_CELL)) ?
                  CNT_W'(MAX_PER_CELL) : electron_count_i;

  // Divide the larger count by the smaller one; the result is only used
  // when the counts differ and both are nonzero.
  bcps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i ((ni_sat > ne_sat) ? ni_sat : ne_sat),
    .divisor_i  ((ni_sat > ne_sat) ? ne_sat : ni_sat),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign gen_start = (state_q == ST_DIV) && div_done;
  assign job       = '{ni: ni_q, ne: ne_q, quot: div_quot, rem: div_rem};

  bcps_gen u_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (gen_start),
    .job_i        (job),
    .pair_valid_o (gen_valid),
    .pair_o       (gen_pair),
    .done_o       (gen_done)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        if (gen_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hold_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (gen_valid) begin
        // Advance: release the held pair, keep the new one.
        res_valid_q  <= hold_valid_q;
        hold_valid_q <= 1'b1;
      end else if (gen_done) begin
        // Drop out the held pair as the cell's last.
        res_valid_q  <= hold_valid_q;
        hold_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ni_q    <= ni_sat;
      ne_q    <= ne_sat;
      tag_r_q <= cell_r_i;
      tag_z_q <= cell_z_i;
    end
    if (gen_valid) begin
      hold_q <= gen_pair;
    end
    if (gen_valid || gen_done) begin
      res_pair_q <= hold_q;
      res_last_q <= gen_done;
      res_r_q    <= tag_r_q;
      res_z_q    <= tag_z_q;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign pair_kind_o    = res_pair_q.kind;
  assign first_index_o  = res_pair_q.first;
  assign second_index_o = res_pair_q.second;
  assign tag_r_o        = res_r_q;
  assign tag_z_o        = res_z_q;
  assign last_pair_o    = res_last_q;

endmodule
